// ----- rtl/tscf_pkg.sv -----
// Shared types, constants and helper functions of the tube scan clock.
`default_nettype none

package tscf_pkg;

   localparam int POSITIONS    = 8;
   localparam int DIGITS       = 6;
   localparam int FADE_LENGTH  = 100;
   localparam int BLINK_PERIOD = 1000;
   localparam int FADE_HALF    = FADE_LENGTH / 2;

   typedef logic [3:0]              glyph_type;
   typedef logic [DIGITS-1:0][3:0]  digits_type;
   typedef logic [6:0]              fade_type;
   typedef logic [9:0]              blink_type;
   typedef logic [2:0]              pos_type;
   typedef logic [1:0]              phase_type;
   typedef logic [1:0]              op_type;

   localparam op_type OP_SCAN   = 2'd0;
   localparam op_type OP_SECOND = 2'd1;
   localparam op_type OP_LOAD   = 2'd2;

   localparam glyph_type GLYPH_MAX_DIGIT = 4'd9;
   localparam glyph_type GLYPH_DOT       = 4'd10;
   localparam glyph_type GLYPH_BLANK     = 4'd11;
   localparam glyph_type CODE_BLANK      = 4'd15;
   localparam glyph_type SELECT_BLANK    = 4'd15;
   localparam glyph_type CODE_BASE       = 4'd10;

   // Digit slots inside the time word.
   localparam int SEC_ONES  = 0;
   localparam int SEC_TENS  = 1;
   localparam int MIN_ONES  = 2;
   localparam int MIN_TENS  = 3;
   localparam int HOUR_ONES = 4;
   localparam int HOUR_TENS = 5;

   // Display positions that show a dot instead of a digit.
   localparam pos_type POS_DOT_LOW  = 3'd2;
   localparam pos_type POS_DOT_HIGH = 3'd5;

   typedef struct packed {
      logic scan;
      logic second;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic [3:0] tube_select;
      logic [3:0] cathode_code;
      logic       dot_off;
   } result_type;

   function automatic glyph_type glyph_now(digits_type d, pos_type pos);
      glyph_type g;
      case (pos)
         3'd0:    g = d[SEC_ONES];
         3'd1:    g = d[SEC_TENS];
         3'd3:    g = d[MIN_ONES];
         3'd4:    g = d[MIN_TENS];
         3'd6:    g = d[HOUR_ONES];
         3'd7:    g = d[HOUR_TENS];
         default: g = GLYPH_DOT;
      endcase
      return g;
   endfunction

   function automatic logic is_digit_pos(pos_type pos);
      return (pos != POS_DOT_LOW) && (pos != POS_DOT_HIGH);
   endfunction

   function automatic result_type drive(pos_type pos, glyph_type g);
      result_type r;
      if (g <= GLYPH_MAX_DIGIT) begin
         r.tube_select  = {1'b0, pos};
         r.cathode_code = (g == 4'd0) ? 4'd0 : (CODE_BASE - g);
         r.dot_off      = 1'b1;
      end else if (g == GLYPH_DOT) begin
         r.tube_select  = {1'b0, pos};
         r.cathode_code = CODE_BLANK;
         r.dot_off      = 1'b0;
      end else begin
         r.tube_select  = SELECT_BLANK;
         r.cathode_code = CODE_BLANK;
         r.dot_off      = 1'b1;
      end
      return r;
   endfunction

   function automatic glyph_type sat(glyph_type v, glyph_type hi);
      return (v > hi) ? hi : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tscf_if.sv -----
// Request and response channel interfaces of the tube scan clock.
`default_nettype none

interface tscf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [1:0] hour_tens_in;
   logic [3:0] hour_ones_in;
   logic [2:0] minute_tens_in;
   logic [3:0] minute_ones_in;
   logic [2:0] second_tens_in;
   logic [3:0] second_ones_in;

   modport source (
      output valid, operation, hour_tens_in, hour_ones_in, minute_tens_in,
             minute_ones_in, second_tens_in, second_ones_in,
      input  ready
   );
   modport sink (
      input  valid, operation, hour_tens_in, hour_ones_in, minute_tens_in,
             minute_ones_in, second_tens_in, second_ones_in,
      output ready
   );
endinterface

interface tscf_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] tube_select;
   logic [3:0] cathode_code;
   logic       dot_off;

   modport source (
      output valid, tube_select, cathode_code, dot_off,
      input  ready
   );
   modport sink (
      input  valid, tube_select, cathode_code, dot_off,
      output ready
   );
   modport monitor (
      input valid, ready, tube_select, cathode_code, dot_off
   );
endinterface

`default_nettype wire

// ----- rtl/tube_scan_clock_with_crossfade.sv -----
// Top level of the tube scan clock: request register, time and display units, response register.
// A scan request passes through the request register and then the response register.
// Throughput: one request per cycle; the request register advances whenever the response
// register is empty or being emptied in the same cycle.
// Reset (synchronous, active high): time 00:00:00, all fades settled, scan at position 0 phase 0,
// blink counter zero, blink position 8 (no blink), both channel registers empty.
`default_nettype none

module tube_scan_clock_with_crossfade #(
   parameter int FADE_LENGTH  = tscf_pkg::FADE_LENGTH,
   parameter int BLINK_PERIOD = tscf_pkg::BLINK_PERIOD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tscf_req_if.sink         req_bus,
   tscf_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_write_data
);

   // Request register. The payload carries no reset; only its valid flag does.
   logic                  req_valid_ff, req_valid_in;
   tscf_pkg::op_type      req_op_ff;
   tscf_pkg::digits_type  req_digits_ff;
   tscf_pkg::digits_type  req_digits_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   tscf_pkg::result_type  rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  advance;
   tscf_pkg::cmd_type     cmd;
   tscf_pkg::digits_type  digits;
   tscf_pkg::result_type  result;
   logic [tscf_pkg::POSITIONS-1:0] fade_start;

   // The held request is executed when the response register has room for a
   // possible result. Every operation runs through the same combinational
   // logic, so the clock state is always current for the next request.
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !req_valid_ff || advance;
   assign req_accept     = req_bus.valid && req_bus.ready;

   always_comb begin
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   // Load digits are widened to the four-bit BCD slots of the time word.
   always_comb begin
      req_digits_in = '0;
      req_digits_in[tscf_pkg::HOUR_TENS] = {2'b00, req_bus.hour_tens_in};
      req_digits_in[tscf_pkg::HOUR_ONES] = req_bus.hour_ones_in;
      req_digits_in[tscf_pkg::MIN_TENS]  = {1'b0, req_bus.minute_tens_in};
      req_digits_in[tscf_pkg::MIN_ONES]  = req_bus.minute_ones_in;
      req_digits_in[tscf_pkg::SEC_TENS]  = {1'b0, req_bus.second_tens_in};
      req_digits_in[tscf_pkg::SEC_ONES]  = req_bus.second_ones_in;
   end

   // Operation decode, qualified by the advance of the request register.
   // The unused operation code decodes to nothing and simply drains.
   always_comb begin
      cmd.scan   = advance && (req_op_ff == tscf_pkg::OP_SCAN);
      cmd.second = advance && (req_op_ff == tscf_pkg::OP_SECOND);
      cmd.load   = advance && (req_op_ff == tscf_pkg::OP_LOAD);
   end

   tscf_time u_time (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .load_digits (req_digits_ff),
      .digits      (digits),
      .fade_start  (fade_start)
   );

   tscf_disp #(
      .FADE_LENGTH  (FADE_LENGTH),
      .BLINK_PERIOD (BLINK_PERIOD)
   ) u_disp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .digits           (digits),
      .fade_start       (fade_start),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   // Only a scan tick produces a response; it loads the response register.
   always_comb begin
      if (cmd.scan) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_op_ff     <= req_bus.operation;
         req_digits_ff <= req_digits_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tube_select  = rsp_data_ff.tube_select;
   assign rsp_bus.cathode_code = rsp_data_ff.cathode_code;
   assign rsp_bus.dot_off      = rsp_data_ff.dot_off;

endmodule

`default_nettype wire

// ----- rtl/tscf_time.sv -----
// Time-of-day counter: BCD ripple on second ticks, saturating load.
`default_nettype none

module tscf_time (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tscf_pkg::cmd_type                 cmd,
   input  wire tscf_pkg::digits_type              load_digits,
   output tscf_pkg::digits_type                   digits,
   output logic [tscf_pkg::POSITIONS-1:0]         fade_start
);

   localparam logic [4:0] ONES_LIMIT  = 5'd10;
   localparam logic [4:0] TENS_LIMIT  = 5'd6;
   localparam logic [4:0] HOUR_WRAP   = 5'd4;
   localparam tscf_pkg::glyph_type HOUR_TENS_WRAP = 4'd2;
   localparam tscf_pkg::glyph_type MAX_ONES       = 4'd9;
   localparam tscf_pkg::glyph_type MAX_TENS       = 4'd5;
   localparam tscf_pkg::glyph_type MAX_HOUR_TENS  = 4'd2;

   tscf_pkg::digits_type digits_ff;
   tscf_pkg::digits_type digits_in;
   logic [4:0] sum_s1;
   logic [4:0] sum_s10;
   logic [4:0] sum_m1;
   logic [4:0] sum_m10;
   logic [4:0] sum_h1;

   assign sum_s1  = {1'b0, digits_ff[tscf_pkg::SEC_ONES]}  + 5'd1;
   assign sum_s10 = {1'b0, digits_ff[tscf_pkg::SEC_TENS]}  + 5'd1;
   assign sum_m1  = {1'b0, digits_ff[tscf_pkg::MIN_ONES]}  + 5'd1;
   assign sum_m10 = {1'b0, digits_ff[tscf_pkg::MIN_TENS]}  + 5'd1;
   assign sum_h1  = {1'b0, digits_ff[tscf_pkg::HOUR_ONES]} + 5'd1;

   always_comb begin
      digits_in  = digits_ff;
      fade_start = '0;
      if (cmd.load) begin
         digits_in[tscf_pkg::HOUR_TENS] =
            tscf_pkg::sat(load_digits[tscf_pkg::HOUR_TENS], MAX_HOUR_TENS);
         digits_in[tscf_pkg::HOUR_ONES] =
            tscf_pkg::sat(load_digits[tscf_pkg::HOUR_ONES], MAX_ONES);
         digits_in[tscf_pkg::MIN_TENS] =
            tscf_pkg::sat(load_digits[tscf_pkg::MIN_TENS], MAX_TENS);
         digits_in[tscf_pkg::MIN_ONES] =
            tscf_pkg::sat(load_digits[tscf_pkg::MIN_ONES], MAX_ONES);
         digits_in[tscf_pkg::SEC_TENS] =
            tscf_pkg::sat(load_digits[tscf_pkg::SEC_TENS], MAX_TENS);
         digits_in[tscf_pkg::SEC_ONES] =
            tscf_pkg::sat(load_digits[tscf_pkg::SEC_ONES], MAX_ONES);
      end else if (cmd.second) begin
         fade_start[0] = 1'b1;
         fade_start[tscf_pkg::POS_DOT_LOW] = 1'b1;
         if (sum_s1 < ONES_LIMIT) begin
            digits_in[tscf_pkg::SEC_ONES] = sum_s1[3:0];
         end else begin
            digits_in[tscf_pkg::SEC_ONES] = 4'd0;
            fade_start[1] = 1'b1;
            if (sum_s10 < TENS_LIMIT) begin
               digits_in[tscf_pkg::SEC_TENS] = sum_s10[3:0];
            end else begin
               digits_in[tscf_pkg::SEC_TENS] = 4'd0;
               fade_start[3] = 1'b1;
               if (sum_m1 < ONES_LIMIT) begin
                  digits_in[tscf_pkg::MIN_ONES] = sum_m1[3:0];
               end else begin
                  digits_in[tscf_pkg::MIN_ONES] = 4'd0;
                  fade_start[4] = 1'b1;
                  if (sum_m10 < TENS_LIMIT) begin
                     digits_in[tscf_pkg::MIN_TENS] = sum_m10[3:0];
                  end else begin
                     digits_in[tscf_pkg::MIN_TENS] = 4'd0;
                     fade_start[6] = 1'b1;
                     // Hour 24 (or any loaded 24..29) wraps to midnight.
                     if ((digits_ff[tscf_pkg::HOUR_TENS] >= HOUR_TENS_WRAP) &&
                         (sum_h1 >= HOUR_WRAP)) begin
                        fade_start[7] = 1'b1;
                        digits_in[tscf_pkg::HOUR_TENS] = 4'd0;
                        digits_in[tscf_pkg::HOUR_ONES] = 4'd0;
                     end else if (sum_h1 >= ONES_LIMIT) begin
                        fade_start[7] = 1'b1;
                        digits_in[tscf_pkg::HOUR_TENS] =
                           digits_ff[tscf_pkg::HOUR_TENS] + 4'd1;
                        digits_in[tscf_pkg::HOUR_ONES] = 4'd0;
                     end else begin
                        digits_in[tscf_pkg::HOUR_ONES] = sum_h1[3:0];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
      end else begin
         digits_ff <= digits_in;
      end
   end

   assign digits = digits_ff;

endmodule

`default_nettype wire

// ----- rtl/tscf_disp.sv -----
// Display scan: position and phase sequencing, crossfade, blink and glyph coding.
`default_nettype none

module tscf_disp #(
   parameter int FADE_LENGTH  = tscf_pkg::FADE_LENGTH,
   parameter int BLINK_PERIOD = tscf_pkg::BLINK_PERIOD
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tscf_pkg::cmd_type                 cmd,
   input  wire tscf_pkg::digits_type              digits,
   input  wire logic [tscf_pkg::POSITIONS-1:0]    fade_start,
   input  wire logic                              csr_write_enable,
   input  wire logic [3:0]                        csr_write_data,
   output tscf_pkg::result_type                   result
);

   localparam int                  FADE_HALF     = FADE_LENGTH / 2;
   localparam tscf_pkg::fade_type  FADE_FULL     = tscf_pkg::fade_type'(FADE_LENGTH);
   localparam tscf_pkg::fade_type  FADE_HALF_V   = tscf_pkg::fade_type'(FADE_HALF);
   localparam tscf_pkg::fade_type  FADE_TWO_HALF = tscf_pkg::fade_type'(2 * FADE_HALF);
   localparam tscf_pkg::blink_type BLINK_LIMIT   = tscf_pkg::blink_type'(BLINK_PERIOD);
   localparam tscf_pkg::blink_type BLINK_HALF    = tscf_pkg::blink_type'(BLINK_PERIOD / 2);
   localparam logic [3:0] BLINK_NONE = 4'd8;
   // Only an odd-length fade reaches a step of twice the half length, and that step is its
   // last one, so the remainder by three there is fixed.
   localparam logic       FADE_LAST_PREV = ((2 * FADE_HALF) % 3) == 0;

   tscf_pkg::fade_type  fade_ff  [tscf_pkg::POSITIONS];
   tscf_pkg::fade_type  fade_in  [tscf_pkg::POSITIONS];
   tscf_pkg::glyph_type prev_ff  [tscf_pkg::POSITIONS];
   tscf_pkg::glyph_type prev_in  [tscf_pkg::POSITIONS];
   tscf_pkg::pos_type   pos_ff, pos_in;
   tscf_pkg::phase_type phase_ff, phase_in;
   tscf_pkg::blink_type blink_ff, blink_in;
   logic [3:0]          blink_pos_ff, blink_pos_in;

   tscf_pkg::fade_type  progress;
   tscf_pkg::blink_type blink_inc;
   logic                settled;
   logic                blink_hide;
   logic                show_prev;
   tscf_pkg::glyph_type cur_glyph;

   assign progress  = fade_ff[pos_ff];
   assign cur_glyph = tscf_pkg::glyph_now(digits, pos_ff);
   assign blink_inc = blink_ff + 10'd1;
   assign blink_in  = cmd.scan ? ((blink_inc >= BLINK_LIMIT) ? '0 : blink_inc) : blink_ff;
   assign settled   = progress >= FADE_FULL;
   assign blink_hide = ({1'b0, pos_ff} == blink_pos_ff) && !(blink_in > BLINK_HALF);

   // Early in a fade the old glyph wins every frame; later it shows on every second
   // frame, and on an odd-length fade's last step only if that step divides by three.
   always_comb begin
      if (progress >= FADE_TWO_HALF) begin
         show_prev = FADE_LAST_PREV;
      end else if (progress >= FADE_HALF_V) begin
         show_prev = !progress[0];
      end else begin
         show_prev = 1'b1;
      end
   end

   always_comb begin
      if (phase_ff == 2'd0) begin
         result = tscf_pkg::drive(3'd0, tscf_pkg::GLYPH_BLANK);
      end else if (settled) begin
         result = blink_hide ? tscf_pkg::drive(3'd0, tscf_pkg::GLYPH_BLANK)
                             : tscf_pkg::drive(pos_ff, cur_glyph);
      end else begin
         result = tscf_pkg::drive(pos_ff, show_prev ? prev_ff[pos_ff] : cur_glyph);
      end
   end

   always_comb begin
      fade_in      = fade_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      blink_pos_in = csr_write_enable ? csr_write_data : blink_pos_ff;
      if (cmd.scan) begin
         if ((phase_ff != 2'd0) && !settled) begin
            fade_in[pos_ff] = progress + 7'd1;
         end
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (cmd.load) begin
         for (int i = 0; i < tscf_pkg::POSITIONS; i++) begin
            fade_in[i] = FADE_FULL;
         end
      end else if (cmd.second) begin
         for (int i = 0; i < tscf_pkg::POSITIONS; i++) begin
            if (fade_start[i]) begin
               fade_in[i] = '0;
               if (tscf_pkg::is_digit_pos(tscf_pkg::pos_type'(i))) begin
                  prev_in[i] = tscf_pkg::glyph_now(digits, tscf_pkg::pos_type'(i));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tscf_pkg::POSITIONS; i++) begin
            fade_ff[i] <= FADE_FULL;
            prev_ff[i] <= tscf_pkg::is_digit_pos(tscf_pkg::pos_type'(i)) ?
                          4'd0 : tscf_pkg::GLYPH_BLANK;
         end
         pos_ff       <= '0;
         phase_ff     <= '0;
         blink_ff     <= '0;
         blink_pos_ff <= BLINK_NONE;
      end else begin
         fade_ff      <= fade_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         blink_ff     <= blink_in;
         blink_pos_ff <= blink_pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tscf_checker.sv -----
// Port-level checker for the tube scan clock and its bind to the top level.
`default_nettype none

module tscf_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [3:0] rsp_tube_select,
   input  wire logic [3:0] rsp_cathode_code,
   input  wire logic       rsp_dot_off
);

   localparam logic [3:0] BLANK = 4'd15;

   // A response waiting for its consumer stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A blanked response blanks everything.
   a_blank_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tube_select == BLANK) |->
         (rsp_cathode_code == BLANK) && rsp_dot_off)
      else $error("blanked response lights a cathode or the dot");

   // A lit dot has no digit cathode and a real position.
   a_dot_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dot_off |->
         (rsp_cathode_code == BLANK) && !rsp_tube_select[3])
      else $error("dot lit together with a digit or without a position");

   // A digit cathode is only ever driven on one of the eight positions.
   a_digit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cathode_code != BLANK) |->
         !rsp_tube_select[3] && (rsp_cathode_code <= 4'd9))
      else $error("digit code outside the display or the code range");

endmodule

bind tube_scan_clock_with_crossfade tscf_checker u_tscf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_tube_select  (rsp_bus.tube_select),
   .rsp_cathode_code (rsp_bus.cathode_code),
   .rsp_dot_off      (rsp_bus.dot_off)
);

`default_nettype wire

// ----- dv/tb_tube_scan_clock_with_crossfade.sv -----
// Self-checking testbench for the tube scan clock with crossfade, driven through its two channels.

module tb_tube_scan_clock_with_crossfade;
   timeunit 1ns;
   timeprecision 1ps;

   // Operation code 3 has no meaning; the block must swallow it without a response.
   localparam tscf_pkg::op_type OP_UNUSED = 2'd3;
   // Blink position value that leaves every tube steady, as after reset.
   localparam logic [3:0] NO_BLINK     = 4'd8;
   localparam logic [3:0] BLINK_ALL_1  = 4'd15;
   localparam logic [3:0] BLINK_ALL_0  = 4'd0;
   localparam logic [3:0] BLINK_HOUR   = 4'd7;
   // Cycles to let a request that makes no response work its way through the pipeline.
   localparam int         DRAIN_CYCLES = 8;
   // Long output stall used to fill the block and push back on the request side.
   localparam int         HOLD_CYCLES  = 300;
   // Enough scans for a fade to run all the way through both of its halves.
   localparam int         FADE_RUN     = 1100;
   localparam int         RANDOM_QUOTA = 200;

   // One request as the sender sees it.
   typedef struct {
      tscf_pkg::op_type op;
      logic [1:0]       hour_tens;
      logic [3:0]       hour_ones;
      logic [2:0]       minute_tens;
      logic [3:0]       minute_ones;
      logic [2:0]       second_tens;
      logic [3:0]       second_ones;
   } clock_request_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   tscf_req_if req_bus ();
   tscf_rsp_if rsp_bus ();

   tube_scan_clock_with_crossfade i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Clock and display predictor. It keeps its own copy of the time digits, the crossfade
   // state of every position, the scan pointer and the blink counter, and is advanced once
   // for every request that the block accepts.
   // ---------------------------------------------------------------------------------------
   tscf_pkg::glyph_type time_digit [tscf_pkg::DIGITS];
   tscf_pkg::glyph_type prior_glyph [tscf_pkg::POSITIONS];
   tscf_pkg::fade_type  fade_step [tscf_pkg::POSITIONS];
   tscf_pkg::pos_type   scan_pos;
   tscf_pkg::phase_type scan_phase;
   tscf_pkg::blink_type blink_count;
   logic [3:0]          blink_at;

   // Tube responses still owed by the block, oldest first.
   tscf_pkg::result_type expected_tubes [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_off_left;
   int n_scan;
   int n_second;
   int n_load;
   int n_unused;
   int n_checked;
   int failures;

   task automatic reset_model();
      foreach (time_digit[i]) time_digit[i] = '0;
      foreach (prior_glyph[i]) begin
         prior_glyph[i] = '0;
         fade_step[i]   = tscf_pkg::fade_type'(tscf_pkg::FADE_LENGTH);
      end
      // Both dot positions start out dark.
      prior_glyph[tscf_pkg::POS_DOT_LOW]  = tscf_pkg::GLYPH_BLANK;
      prior_glyph[tscf_pkg::POS_DOT_HIGH] = tscf_pkg::GLYPH_BLANK;
      scan_pos    = '0;
      scan_phase  = '0;
      blink_count = '0;
      blink_at    = NO_BLINK;
   endtask

   // The glyph a position shows right now. Positions past each dot map one or two slots down
   // into the time digits.
   function automatic tscf_pkg::glyph_type displayed_digit(tscf_pkg::pos_type p);
      if (p == tscf_pkg::POS_DOT_LOW || p == tscf_pkg::POS_DOT_HIGH) begin
         return tscf_pkg::GLYPH_DOT;
      end
      if (p > tscf_pkg::POS_DOT_HIGH) begin
         return time_digit[p - 3'd2];
      end
      if (p > tscf_pkg::POS_DOT_LOW) begin
         return time_digit[p - 3'd1];
      end
      return time_digit[p];
   endfunction

   // Turn a glyph at a position into the three response fields.
   function automatic tscf_pkg::result_type tube_code(tscf_pkg::pos_type p,
                                                      tscf_pkg::glyph_type g);
      tscf_pkg::result_type r;
      r.tube_select  = {1'b0, p};
      r.cathode_code = tscf_pkg::CODE_BLANK;
      r.dot_off      = 1'b1;
      if (g <= tscf_pkg::GLYPH_MAX_DIGIT) begin
         // The driver counts its cathodes backward, except that zero stays zero.
         r.cathode_code = (g == 4'd0) ? 4'd0 : tscf_pkg::CODE_BASE - g;
      end else if (g == tscf_pkg::GLYPH_DOT) begin
         r.dot_off = 1'b0;
      end else begin
         r.tube_select = tscf_pkg::SELECT_BLANK;
      end
      return r;
   endfunction

   function automatic tscf_pkg::glyph_type clip_digit(int v, int hi);
      return tscf_pkg::glyph_type'((v > hi) ? hi : v);
   endfunction

   task automatic begin_fade(int p, tscf_pkg::glyph_type old);
      prior_glyph[p] = old;
      fade_step[p]   = '0;
   endtask

   // Ripple the time up by one second. Every digit that changes fades from its old value, and
   // the low dot fades in from dark on every second.
   task automatic advance_second();
      begin_fade(0, time_digit[tscf_pkg::SEC_ONES]);
      fade_step[tscf_pkg::POS_DOT_LOW] = '0;
      time_digit[tscf_pkg::SEC_ONES]++;
      if (time_digit[tscf_pkg::SEC_ONES] < 10) return;
      time_digit[tscf_pkg::SEC_ONES] = '0;
      begin_fade(1, time_digit[tscf_pkg::SEC_TENS]);
      time_digit[tscf_pkg::SEC_TENS]++;
      if (time_digit[tscf_pkg::SEC_TENS] < 6) return;
      time_digit[tscf_pkg::SEC_TENS] = '0;
      begin_fade(3, time_digit[tscf_pkg::MIN_ONES]);
      time_digit[tscf_pkg::MIN_ONES]++;
      if (time_digit[tscf_pkg::MIN_ONES] < 10) return;
      time_digit[tscf_pkg::MIN_ONES] = '0;
      begin_fade(4, time_digit[tscf_pkg::MIN_TENS]);
      time_digit[tscf_pkg::MIN_TENS]++;
      if (time_digit[tscf_pkg::MIN_TENS] < 6) return;
      time_digit[tscf_pkg::MIN_TENS] = '0;
      begin_fade(6, time_digit[tscf_pkg::HOUR_ONES]);
      time_digit[tscf_pkg::HOUR_ONES]++;
      // Twenty-four hours roll back to midnight. A loaded hour from 24 to 29 is caught here
      // too, at its first carry.
      if (time_digit[tscf_pkg::HOUR_TENS] >= 2 && time_digit[tscf_pkg::HOUR_ONES] >= 4) begin
         begin_fade(7, time_digit[tscf_pkg::HOUR_TENS]);
         time_digit[tscf_pkg::HOUR_TENS] = '0;
         time_digit[tscf_pkg::HOUR_ONES] = '0;
      end else if (time_digit[tscf_pkg::HOUR_ONES] >= 10) begin
         begin_fade(7, time_digit[tscf_pkg::HOUR_TENS]);
         time_digit[tscf_pkg::HOUR_TENS]++;
         time_digit[tscf_pkg::HOUR_ONES] = '0;
      end
   endtask

   // Advance the predictor by one accepted request and say what response, if any, it makes.
   task automatic apply_request(input clock_request_type rq, output bit has_result,
                                output tscf_pkg::result_type res);
      int t;
      int divisor;
      has_result = 1'b0;
      res        = '0;
      case (rq.op)
         tscf_pkg::OP_SCAN: begin
            has_result  = 1'b1;
            blink_count = (blink_count + 1 >= tscf_pkg::BLINK_PERIOD) ? '0
                                                                      : blink_count + 1'b1;
            if (scan_phase == '0) begin
               // The first phase of every position blanks all tubes.
               res = tube_code('0, tscf_pkg::GLYPH_BLANK);
            end else begin
               t = fade_step[scan_pos];
               if (t >= tscf_pkg::FADE_LENGTH) begin
                  // A settled tube that is chosen to blink is dark for the first half of
                  // the blink period.
                  if (blink_at == {1'b0, scan_pos} &&
                      blink_count <= tscf_pkg::BLINK_PERIOD / 2) begin
                     res = tube_code('0, tscf_pkg::GLYPH_BLANK);
                  end else begin
                     res = tube_code(scan_pos, displayed_digit(scan_pos));
                  end
               end else begin
                  // Early in the fade the old glyph holds every lit phase; in the second
                  // half it alternates with the new one.
                  divisor = t / tscf_pkg::FADE_HALF + 1;
                  res = tube_code(scan_pos, (t % divisor == 0) ? prior_glyph[scan_pos]
                                                               : displayed_digit(scan_pos));
                  fade_step[scan_pos] = tscf_pkg::fade_type'(t + 1);
               end
            end
            if (scan_phase == 2'd3) begin
               scan_phase = '0;
               scan_pos   = scan_pos + 1'b1;
            end else begin
               scan_phase = scan_phase + 1'b1;
            end
         end
         tscf_pkg::OP_SECOND: begin
            advance_second();
         end
         tscf_pkg::OP_LOAD: begin
            time_digit[tscf_pkg::HOUR_TENS] = clip_digit(rq.hour_tens, 2);
            time_digit[tscf_pkg::HOUR_ONES] = clip_digit(rq.hour_ones, 9);
            time_digit[tscf_pkg::MIN_TENS]  = clip_digit(rq.minute_tens, 5);
            time_digit[tscf_pkg::MIN_ONES]  = clip_digit(rq.minute_ones, 9);
            time_digit[tscf_pkg::SEC_TENS]  = clip_digit(rq.second_tens, 5);
            time_digit[tscf_pkg::SEC_ONES]  = clip_digit(rq.second_ones, 9);
            foreach (fade_step[i]) fade_step[i] = tscf_pkg::fade_type'(tscf_pkg::FADE_LENGTH);
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // Request builders.
   // ---------------------------------------------------------------------------------------

   // All digit fields take random values over their full width, in range or not.
   function automatic clock_request_type make_request(tscf_pkg::op_type op);
      clock_request_type rq;
      rq.op          = op;
      rq.hour_tens   = 2'($urandom_range(3));
      rq.hour_ones   = 4'($urandom_range(15));
      rq.minute_tens = 3'($urandom_range(7));
      rq.minute_ones = 4'($urandom_range(15));
      rq.second_tens = 3'($urandom_range(7));
      rq.second_ones = 4'($urandom_range(15));
      return rq;
   endfunction

   function automatic clock_request_type request_with(tscf_pkg::op_type op, int ht, int ho,
                                                      int mt, int mo, int st, int so);
      clock_request_type rq;
      rq.op          = op;
      rq.hour_tens   = 2'(ht);
      rq.hour_ones   = 4'(ho);
      rq.minute_tens = 3'(mt);
      rq.minute_ones = 4'(mo);
      rq.second_tens = 3'(st);
      rq.second_ones = 4'(so);
      return rq;
   endfunction

   // A time with each digit in range (the hour may go past 23) that often sits just before a
   // carry, so that a few seconds ripple deep into the minutes and hours.
   function automatic clock_request_type rollover_load();
      clock_request_type rq;
      rq.op          = tscf_pkg::OP_LOAD;
      rq.hour_tens   = 2'($urandom_range(1) ? 2 : $urandom_range(2));
      rq.hour_ones   = 4'($urandom_range(1) ? 3 : $urandom_range(9));
      rq.minute_tens = 3'($urandom_range(1) ? 5 : $urandom_range(5));
      rq.minute_ones = 4'($urandom_range(1) ? 9 : $urandom_range(9));
      rq.second_tens = 3'($urandom_range(1) ? 5 : $urandom_range(5));
      rq.second_ones = 4'($urandom_range(1) ? 9 : $urandom_range(9));
      return rq;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver. Idle cycles are inserted before the request at the current idle rate;
   // valid stays high from one request to the next when there is no gap.
   // ---------------------------------------------------------------------------------------
   task automatic send_request(input clock_request_type rq);
      bit                   has_result;
      tscf_pkg::result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= rq.op;
      req_bus.hour_tens_in   <= rq.hour_tens;
      req_bus.hour_ones_in   <= rq.hour_ones;
      req_bus.minute_tens_in <= rq.minute_tens;
      req_bus.minute_ones_in <= rq.minute_ones;
      req_bus.second_tens_in <= rq.second_tens;
      req_bus.second_ones_in <= rq.second_ones;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_request(rq, has_result, res);
      if (has_result) expected_tubes.push_back(res);
      case (rq.op)
         tscf_pkg::OP_SCAN:   n_scan++;
         tscf_pkg::OP_SECOND: n_second++;
         tscf_pkg::OP_LOAD:   n_load++;
         default:             n_unused++;
      endcase
   endtask

   // Stop offering requests and wait until every owed response has come back, then a little
   // longer for requests that make no response.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_tubes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The register is only ever written with the block idle.
   task automatic write_blink_position(logic [3:0] where);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= where;
      @(posedge clock);
      blink_at = where;
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side. The receiver stalls at the current rate, or holds off entirely while a
   // hold-off count is running.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Every accepted response is checked against the oldest owed one.
   always @(posedge clock) begin : check_tubes
      tscf_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         n_checked++;
         if (expected_tubes.size() == 0) begin
            $error("tube response with none owed: tube_select %0d cathode_code %0d dot_off %0d",
                   rsp_bus.tube_select, rsp_bus.cathode_code, rsp_bus.dot_off);
            failures++;
         end else begin
            want = expected_tubes.pop_front();
            if (rsp_bus.tube_select !== want.tube_select) begin
               $error("tube_select: expected %0d, actual %0d",
                      want.tube_select, rsp_bus.tube_select);
               failures++;
            end
            if (rsp_bus.cathode_code !== want.cathode_code) begin
               $error("cathode_code: expected %0d, actual %0d",
                      want.cathode_code, rsp_bus.cathode_code);
               failures++;
            end
            if (rsp_bus.dot_off !== want.dot_off) begin
               $error("dot_off: expected %0d, actual %0d", want.dot_off, rsp_bus.dot_off);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Loads at both ends of every field, each kind of rollover, and the unused operation.
   task automatic test_time_corners();
      // Position 0 straight after reset: one blanked phase, then three steady zeros.
      repeat (4) send_request(make_request(tscf_pkg::OP_SCAN));
      // Every digit field at its top bit pattern saturates, giving the hour 29.
      send_request(request_with(tscf_pkg::OP_LOAD, 3, 15, 7, 15, 7, 15));
      // The slipped hour returns to midnight at its next carry.
      send_request(make_request(tscf_pkg::OP_SECOND));
      send_request(request_with(tscf_pkg::OP_LOAD, 2, 3, 5, 9, 5, 9));
      send_request(make_request(tscf_pkg::OP_SECOND));
      // Hour ones carrying into hour tens.
      send_request(request_with(tscf_pkg::OP_LOAD, 1, 9, 5, 9, 5, 9));
      send_request(make_request(tscf_pkg::OP_SECOND));
      send_request(request_with(tscf_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0));
      send_request(request_with(OP_UNUSED, 3, 15, 7, 15, 7, 15));
      // Seconds ones and the low dot begin to fade; scan through the positions behind them.
      send_request(make_request(tscf_pkg::OP_SECOND));
      repeat (12) send_request(make_request(tscf_pkg::OP_SCAN));
   endtask

   // Point the blink at the position about to be scanned while the blink counter is still in
   // its dark half, so its lit phases come out blanked.
   task automatic test_blink_gate();
      write_blink_position({1'b0, scan_pos});
      repeat (4) send_request(make_request(tscf_pkg::OP_SCAN));
   endtask

   // Random mix of well-formed load, tick and scan sequences, with some noise.
   task automatic test_random_traffic(int idle_pct, int stall_pct, logic [3:0] blink);
      int sent;
      int pick;
      int run;
      write_blink_position(blink);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_QUOTA) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_request((pick < 6) ? make_request(tscf_pkg::OP_LOAD) : rollover_load());
            sent++;
         end else if (pick < 35) begin
            run = $urandom_range(3, 1);
            repeat (run) send_request(make_request(tscf_pkg::OP_SECOND));
            sent += run;
         end else if (pick < 40) begin
            send_request(make_request(OP_UNUSED));
         end else begin
            run = $urandom_range(40, 1);
            repeat (run) send_request(make_request(tscf_pkg::OP_SCAN));
            sent += run;
         end
      end
   endtask

   // The receiver holds off for a long stretch while scans keep coming, so the block fills up
   // and has to refuse requests until the stall ends.
   task automatic test_output_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = HOLD_CYCLES;
      repeat (40) send_request(make_request(tscf_pkg::OP_SCAN));
   endtask

   // One carry sets several positions fading, then a long undisturbed scan lets each fade run
   // through both halves and settle. The high dot, which never fades, blinks meanwhile.
   task automatic test_fade_depth();
      clock_request_type rq;
      write_blink_position({1'b0, tscf_pkg::POS_DOT_HIGH});
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      rq = rollover_load();
      rq.second_tens = 3'd5;
      rq.second_ones = 4'd9;
      send_request(rq);
      send_request(make_request(tscf_pkg::OP_SECOND));
      repeat (FADE_RUN) send_request(make_request(tscf_pkg::OP_SCAN));
   endtask

   // Generous upper bound on the whole run.
   initial begin : watchdog
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset_model();
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.operation      = tscf_pkg::OP_SCAN;
      req_bus.hour_tens_in   = '0;
      req_bus.hour_ones_in   = '0;
      req_bus.minute_tens_in = '0;
      req_bus.minute_ones_in = '0;
      req_bus.second_tens_in = '0;
      req_bus.second_ones_in = '0;
      rsp_bus.ready          = 1'b0;
      send_idle_pct          = 0;
      rsp_stall_pct          = 0;
      hold_off_left          = 0;
      n_scan                 = 0;
      n_second               = 0;
      n_load                 = 0;
      n_unused               = 0;
      n_checked              = 0;
      failures               = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_time_corners();
      test_blink_gate();
      test_random_traffic(0, 0, BLINK_ALL_1);
      test_random_traffic(52, 0, BLINK_ALL_0);
      test_output_stall();
      test_random_traffic(0, 52, BLINK_HOUR);
      test_random_traffic(37, 37, NO_BLINK);
      test_fade_depth();
      wait_drained();

      $display("Sent %0d scan, %0d second, %0d load and %0d unused requests; checked %0d tubes.",
               n_scan, n_second, n_load, n_unused, n_checked);
      $display("Runs covered rollovers, saturated loads, blinking, full fades and a long stall.");
      if (failures == 0 && expected_tubes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
